// File: sv/rcn_pkg.sv
package rcn_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned RAW_W  = 12;
  localparam int unsigned CH_W   = 5;
  localparam int unsigned NORM_W = 16;
  // Magnitude bits below full scale, one quotient bit per divider step.
  localparam int unsigned MAG_W  = 15;
  // Signed working width for trim, dead zone and divisor arithmetic.
  localparam int unsigned SW_W   = 14;
  localparam int unsigned CNT_W  = 4;

  localparam logic [CH_W-1:0] MIN_CHANNELS = 5'd4;
  localparam logic [MAG_W-1:0] Q15_MAX     = 15'h7fff;

  // Configuration register indexes.
  localparam logic CFG_FS_THRESHOLD = 1'b0;
  localparam logic CFG_FS_CHANNEL   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_SPLIT,
    S_START,
    S_WAIT
  } state_e;

  // Per-item frame status, settled when the item is taken.
  typedef struct packed {
    logic chan_valid;
    logic sig_lost;
  } frame_info_t;

endpackage

// File: sv/rcn_frame.sv
module rcn_frame import rcn_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [RAW_W-1:0]  raw_value_i,
  input  logic [RAW_W-1:0]  cal_min_i,
  input  logic [RAW_W-1:0]  cal_max_i,
  input  logic              link_lost_i,
  input  logic              receiver_failsafe_i,
  input  logic [CH_W-1:0]   channel_count_i,
  input  logic              frame_end_i,
  input  logic [RAW_W-1:0]  fs_threshold_i,
  input  logic [CH_W-1:0]   fs_channel_i,
  output frame_info_t       info_o
);

  localparam logic [CH_W:0] MaxCh = (CH_W+1)'(MAX_CHANNELS);

  logic          tripped_q, tripped_d;
  logic [CH_W:0] limit;
  logic          trip, tripped_now;

  always_comb begin
    limit = ({1'b0, channel_count_i} < MaxCh) ? {1'b0, channel_count_i} : MaxCh;
    info_o.chan_valid = {1'b0, channel_i} < limit;
    // The check compares the unclamped pulse with a threshold outside the calibrated limits.
    trip = (fs_threshold_i != '0) && (channel_i == fs_channel_i) &&
           (((fs_threshold_i < cal_min_i) && (raw_value_i < fs_threshold_i)) ||
            ((fs_threshold_i > cal_max_i) && (raw_value_i > fs_threshold_i)));
    tripped_now = tripped_q | trip;
    info_o.sig_lost = frame_end_i &
                      (link_lost_i | receiver_failsafe_i |
                       (channel_count_i < MIN_CHANNELS) | tripped_now);
    tripped_d = tripped_q;
    if (accept_i) begin
      tripped_d = frame_end_i ? 1'b0 : tripped_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tripped_q <= 1'b0;
    end else begin
      tripped_q <= tripped_d;
    end
  end

endmodule

// File: sv/rcn_div.sv
module rcn_div import rcn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              zero_i,
  input  logic [RAW_W-1:0]  num_i,
  input  logic [RAW_W-1:0]  den_i,
  output logic              done_o,
  output logic [MAG_W-1:0]  mag_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAW_W-1:0]  rem_q, rem_d;
  logic [RAW_W-1:0]  den_q, den_d;
  logic [MAG_W-1:0]  quo_q, quo_d;
  logic [RAW_W:0]    rem2, diff;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    rem2   = {rem_q, 1'b0};
    diff   = rem2 - {1'b0, den_q};
    if (start_i) begin
      den_d = den_i;
      rem_d = num_i;
      cnt_d = CNT_W'(MAG_W - 1);
      if (zero_i) begin
        quo_d  = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (num_i >= den_i) begin
        // A quotient of one or more saturates just below full scale.
        quo_d  = Q15_MAX;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        quo_d  = '0;
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      if (!diff[RAW_W]) begin
        rem_d = diff[RAW_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = rem2[RAW_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign mag_o  = quo_q;

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done together");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == '0) && !start_i |=> done_q)
    else $error("divider did not finish after its last step");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !start_i |=> done_q && $stable(quo_q))
    else $error("divider result changed before the next start");

endmodule

// File: sv/rc_channel_normalizer.sv
// Channel     Direction  Handshake              Payload
// in          input      in_valid_i/in_ready_o  channel, raw pulse, calibration, frame flags
// out         output     out_valid_o/out_ready_i channel_out, normalized, status flags
// cfg         input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item that needs division reaches the output register via the clamp and split
// preparation states, the start state, 15 radix-2 divider steps and a handover that waits
// for output room. Items in the dead zone, invalid or saturating ones bypass the steps.
// The next item is taken in the cycle after the handover, even while the result waits.
// Reset is asynchronous, active low and clears the failsafe latch and control registers.
module rc_channel_normalizer import rcn_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 18
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CH_W-1:0]          channel_i,
  input  logic [RAW_W-1:0]         raw_value_i,
  input  logic [RAW_W-1:0]         cal_min_i,
  input  logic [RAW_W-1:0]         cal_max_i,
  input  logic [RAW_W-1:0]         cal_trim_i,
  input  logic [RAW_W-1:0]         dead_zone_i,
  input  logic                     reverse_i,
  input  logic                     link_lost_i,
  input  logic                     receiver_failsafe_i,
  input  logic [CH_W-1:0]          channel_count_i,
  input  logic                     frame_end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CH_W-1:0]          channel_out_o,
  output logic signed [NORM_W-1:0] normalized_o,
  output logic                     channel_valid_o,
  output logic                     frame_lost_o,
  output logic                     frame_last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [RAW_W-1:0]         cfg_data_i
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [RAW_W-1:0] fs_thr_q;
  logic [CH_W-1:0]  fs_ch_q;

  // Item registers, loaded when the item is taken.
  logic [CH_W-1:0]  ch_q;
  logic [RAW_W-1:0] raw_q, lo_q, hi_q, trim_q, dz_q;
  logic             rev_q, last_q;
  frame_info_t      info_q, info;

  // Preparation registers.
  logic [RAW_W-1:0]       v_q, v_d;
  logic [RAW_W:0]         tdp_q, tdp_d;
  logic signed [SW_W-1:0] tdm_q, tdm_d;
  logic [RAW_W-1:0]       num_q, num_d, den_q, den_d;
  logic                   zero_q, zero_d, neg_q, neg_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic [CH_W-1:0]          ch_out_q;
  logic signed [NORM_W-1:0] norm_q;
  logic                     cvalid_q, slost_q, flast_q;

  logic                   accept, load_out, out_room;
  logic                   div_start, div_done;
  logic [MAG_W-1:0]       div_mag;
  logic [RAW_W-1:0]       v_lo;
  logic                   above, below;
  logic signed [SW_W-1:0] v_s, lo_s, hi_s, tdp_s, den_s, num_s;
  logic [NORM_W-1:0]      mag_ext;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_room    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_thr_q <= '0;
      fs_ch_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FS_THRESHOLD: fs_thr_q <= cfg_data_i;
        CFG_FS_CHANNEL:   fs_ch_q  <= cfg_data_i[CH_W-1:0];
        default:          fs_thr_q <= fs_thr_q;
      endcase
    end
  end

  // Channel limit and the frame's failsafe latch are settled at acceptance, in item order.
  rcn_frame #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_frame (
    .clk_i,
    .rst_ni,
    .accept_i            (accept),
    .channel_i,
    .raw_value_i,
    .cal_min_i,
    .cal_max_i,
    .link_lost_i,
    .receiver_failsafe_i,
    .channel_count_i,
    .frame_end_i,
    .fs_threshold_i      (fs_thr_q),
    .fs_channel_i        (fs_ch_q),
    .info_o              (info)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= channel_i;
      raw_q  <= raw_value_i;
      lo_q   <= cal_min_i;
      hi_q   <= cal_max_i;
      trim_q <= cal_trim_i;
      dz_q   <= dead_zone_i;
      rev_q  <= reverse_i;
      last_q <= frame_end_i;
      info_q <= info;
    end
  end

  // First preparation cycle: clamp the pulse (minimum first, then maximum) and
  // form both edges of the dead zone.
  always_comb begin
    v_lo  = (raw_q < lo_q) ? lo_q : raw_q;
    v_d   = (v_lo > hi_q) ? hi_q : v_lo;
    tdp_d = {1'b0, trim_q} + {1'b0, dz_q};
    tdm_d = $signed({2'b00, trim_q}) - $signed({2'b00, dz_q});
  end

  // Second preparation cycle: pick the side of trim, its numerator and divisor.
  // Inside the dead zone, on an invalid channel or with a non-positive divisor the
  // magnitude is zero.
  always_comb begin
    v_s   = $signed({2'b00, v_q});
    lo_s  = $signed({2'b00, lo_q});
    hi_s  = $signed({2'b00, hi_q});
    tdp_s = $signed({1'b0, tdp_q});
    above = v_s > tdp_s;
    below = v_s < tdm_q;
    if (above) begin
      num_s = v_s - tdp_s;
      den_s = hi_s - tdp_s;
    end else begin
      num_s = tdm_q - v_s;
      den_s = tdm_q - lo_s;
    end
    num_d  = num_s[RAW_W-1:0];
    den_d  = den_s[RAW_W-1:0];
    zero_d = !info_q.chan_valid || !(above || below) || (den_s <= $signed(SW_W'(0)));
    neg_d  = below ^ rev_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLAMP) begin
      v_q   <= v_d;
      tdp_q <= tdp_d;
      tdm_q <= tdm_d;
    end
    if (state_q == S_SPLIT) begin
      num_q  <= num_d;
      den_q  <= den_d;
      zero_q <= zero_d;
      neg_q  <= neg_d;
    end
  end

  rcn_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .zero_i  (zero_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .mag_o   (div_mag)
  );

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: state_d = S_SPLIT;
      S_SPLIT: state_d = S_START;
      S_START: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_done && out_room) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign mag_ext = {1'b0, div_mag};

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ch_out_q <= ch_q;
      norm_q   <= neg_q ? $signed(-mag_ext) : $signed(mag_ext);
      cvalid_q <= info_q.chan_valid;
      slost_q  <= info_q.sig_lost;
      flast_q  <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_out_o   = ch_out_q;
  assign normalized_o    = norm_q;
  assign channel_valid_o = cvalid_q;
  assign frame_lost_o    = slost_q;
  assign frame_last_o    = flast_q;

  a_accept_to_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_CLAMP)
    else $error("taken item did not enter preparation");

  a_lost_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> !frame_lost_o)
    else $error("frame loss reported outside a frame end");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !channel_valid_o |-> normalized_o == '0)
    else $error("invalid channel gave a non-zero value");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_out_o) &&
      $stable(normalized_o) && $stable(frame_last_o))
    else $error("waiting result overwritten");

endmodule

// File: sim/tb_rc_channel_normalizer.sv
module tb_rc_channel_normalizer;
  import rcn_pkg::*;

  // Channel limit of the block under test, handed down as its parameter.
  localparam int unsigned MAX_CH = 18;
  // Length of the long receiver hold-off that forces the block to back up.
  localparam int HOLD_CYCLES = 400;
  // Cycles allowed after the last result for stray output to show itself.
  localparam int SETTLE_CYCLES = 40;
  // Hard limit on the run, several times the slowest correct run.
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int CLK_HALF = 6;

  // One channel pulse with its calibration and the frame flags.
  typedef struct {
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] cal_min;
    logic [RAW_W-1:0] cal_max;
    logic [RAW_W-1:0] trim;
    logic [RAW_W-1:0] dz;
    logic             rev;
    logic             lost;
    logic             rxfs;
    logic [CH_W-1:0]  count;
    logic             last;
  } rc_item_t;

  // One normalised channel as the block should hand it out.
  typedef struct {
    logic [CH_W-1:0]          channel;
    logic signed [NORM_W-1:0] norm;
    logic                     chan_ok;
    logic                     sig_lost;
    logic                     last;
  } rc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Sender side: the item on offer is held in cur_pulse until it is taken.
  logic     in_valid = 1'b0;
  logic     in_ready;
  rc_item_t cur_pulse = '{default: '0};

  // Receiver side.
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CH_W-1:0]          channel_out;
  logic signed [NORM_W-1:0] normalized;
  logic                     channel_valid;
  logic                     frame_lost;
  logic                     frame_last;

  // Register write channel.
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = CFG_FS_THRESHOLD;
  logic [RAW_W-1:0] cfg_data = '0;

  // Items waiting to be offered, and normalised results still owed by the block.
  rc_item_t   pulses_pending[$];
  rc_result_t norm_results_due[$];

  // Our own copy of the register file and of the failsafe latch.
  logic [RAW_W-1:0] fs_thr = '0;
  logic [CH_W-1:0]  fs_ch = '0;
  logic             fs_tripped = 1'b0;

  // Idling controls, changed by the sequence only between clock edges.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int err_count = 0;

  rc_channel_normalizer #(
    .MAX_CHANNELS(MAX_CH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .channel_i          (cur_pulse.channel),
    .raw_value_i        (cur_pulse.raw),
    .cal_min_i          (cur_pulse.cal_min),
    .cal_max_i          (cur_pulse.cal_max),
    .cal_trim_i         (cur_pulse.trim),
    .dead_zone_i        (cur_pulse.dz),
    .reverse_i          (cur_pulse.rev),
    .link_lost_i        (cur_pulse.lost),
    .receiver_failsafe_i(cur_pulse.rxfs),
    .channel_count_i    (cur_pulse.count),
    .frame_end_i        (cur_pulse.last),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .channel_out_o      (channel_out),
    .normalized_o       (normalized),
    .channel_valid_o    (channel_valid),
    .frame_lost_o       (frame_lost),
    .frame_last_o       (frame_last),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Magnitude of a scaled deflection: floor(num * 2^15 / den), saturated just
  // below full scale. A divisor of zero or less gives no deflection at all.
  function automatic int q15_magnitude(int num, int den);
    longint quot;
    if (den <= 0) return 0;
    quot = (longint'(num) * 32768) / den;
    return (quot > longint'(Q15_MAX)) ? int'(Q15_MAX) : int'(quot);
  endfunction

  // Clamp the pulse into its calibrated span, then scale it separately on each
  // side of the dead zone around trim. The clamp takes the minimum first, so an
  // inverted calibration always lands on the maximum.
  function automatic logic signed [NORM_W-1:0] stick_deflection(rc_item_t it);
    int v;
    int lo;
    int hi;
    int trim;
    int dz;
    int mag;
    logic neg;
    v = int'(it.raw);
    lo = int'(it.cal_min);
    hi = int'(it.cal_max);
    trim = int'(it.trim);
    dz = int'(it.dz);
    mag = 0;
    neg = 1'b0;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v > trim + dz) begin
      mag = q15_magnitude(v - trim - dz, hi - trim - dz);
    end else if (v < trim - dz) begin
      mag = q15_magnitude(trim - dz - v, trim - lo - dz);
      neg = 1'b1;
    end
    if (it.rev) neg = !neg;
    return NORM_W'(neg ? -mag : mag);
  endfunction

  // Works out the result of one accepted item and moves the failsafe latch on.
  // The latch looks at the unclamped pulse and is checked even on channels that
  // lie beyond the channel limit.
  function automatic rc_result_t normalise_pulse(rc_item_t it);
    rc_result_t r;
    int limit;
    limit = (it.count < MAX_CH) ? int'(it.count) : MAX_CH;
    r.channel = it.channel;
    r.chan_ok = (int'(it.channel) < limit);
    r.norm = r.chan_ok ? stick_deflection(it) : '0;
    r.last = it.last;
    r.sig_lost = 1'b0;
    if (fs_thr != '0 && it.channel == fs_ch) begin
      if ((fs_thr < it.cal_min && it.raw < fs_thr) ||
          (fs_thr > it.cal_max && it.raw > fs_thr)) begin
        fs_tripped = 1'b1;
      end
    end
    if (it.last) begin
      r.sig_lost = it.lost | it.rxfs | (it.count < MIN_CHANNELS) | fs_tripped;
      fs_tripped = 1'b0;
    end
    return r;
  endfunction

  // Sender. The expectation is formed on the edge at which the item is taken;
  // a fresh item may be offered on that same edge, so valid is written once.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) norm_results_due.push_back(normalise_pulse(cur_pulse));
      if (!in_valid || in_ready) begin
        if (pulses_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pulse <= pulses_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. A requested hold-off is counted down here and overrides the
  // random stalling for its whole length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endfunction

  // Every result taken from the block is compared with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    rc_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (norm_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual channel %0d value %0d",
                 $time, channel_out, normalized);
        err_count++;
      end else begin
        want = norm_results_due.pop_front();
        check_field("channel_out", int'(want.channel), int'(channel_out));
        check_field("normalized", int'(want.norm), int'(normalized));
        check_field("channel_valid", int'(want.chan_ok), int'(channel_valid));
        check_field("frame_lost", int'(want.sig_lost), int'(frame_lost));
        check_field("frame_last", int'(want.last), int'(frame_last));
      end
    end
  end

  // Register writes are only issued while the block holds no item, so our copy
  // of the registers can simply follow each write as it is taken.
  task automatic write_reg(input logic idx, input logic [RAW_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FS_THRESHOLD) fs_thr = data;
    else fs_ch = data[CH_W-1:0];
  endtask

  task automatic push_pulse(input int ch, input int raw, input int lo, input int hi,
                            input int trim, input int dz, input bit rev, input bit lost,
                            input bit rxfs, input int cnt, input bit last);
    rc_item_t it;
    it.channel = CH_W'(ch);
    it.raw = RAW_W'(raw);
    it.cal_min = RAW_W'(lo);
    it.cal_max = RAW_W'(hi);
    it.trim = RAW_W'(trim);
    it.dz = RAW_W'(dz);
    it.rev = rev;
    it.lost = lost;
    it.rxfs = rxfs;
    it.count = CH_W'(cnt);
    it.last = last;
    pulses_pending.push_back(it);
  endtask

  // Random traffic. Most of it is whole frames with plausible calibration, so
  // the failsafe latch and the frame-end verdict are exercised properly; the
  // rest is free noise, odd channel counts, wild calibration and frames that
  // never see their end flag.
  task automatic gen_frames(input int n);
    int made;
    int len;
    int c;
    int lo;
    int hi;
    int trim;
    int dz;
    int raw;
    int cnt;
    bit lost;
    bit rxfs;
    bit broken;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        push_pulse($urandom_range(31), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   $urandom_range(31), 1'($urandom_range(1)));
        made++;
      end else begin
        len = $urandom_range(1, 20);
        cnt = ($urandom_range(4) == 0) ? $urandom_range(31) : len;
        lost = ($urandom_range(19) == 0);
        rxfs = ($urandom_range(19) == 0);
        broken = ($urandom_range(19) == 0);
        for (c = 0; c < len; c++) begin
          lo = $urandom_range(800, 1100);
          hi = $urandom_range(1900, 2200);
          // Roughly one channel in five is a throttle, trimmed at its low end.
          trim = ($urandom_range(4) == 0) ? lo : $urandom_range(1400, 1600);
          dz = $urandom_range(0, 60);
          raw = $urandom_range(lo - 150, hi + 150);
          if ($urandom_range(9) == 0) begin
            lo = $urandom_range(4095);
            hi = $urandom_range(4095);
            trim = $urandom_range(4095);
            dz = $urandom_range(600);
            raw = $urandom_range(4095);
          end
          // Now and then drive the watched channel past the threshold, from
          // below a raised minimum or above a lowered maximum.
          if (fs_thr != '0 && c == fs_ch && $urandom_range(2) == 0) begin
            if ($urandom_range(1) == 0) begin
              lo = (fs_thr + 300 > 4095) ? 4095 : fs_thr + $urandom_range(1, 300);
              raw = $urandom_range(fs_thr);
            end else begin
              hi = (fs_thr < 300) ? 0 : fs_thr - $urandom_range(1, 300);
              raw = $urandom_range(fs_thr, 4095);
            end
          end
          push_pulse(c, raw, lo, hi, trim, dz, 1'($urandom_range(1)), lost, rxfs, cnt,
                     (c == len - 1) && !broken);
          made++;
        end
      end
    end
  endtask

  // Returns once every item has been taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pulses_pending.size() != 0 || in_valid || norm_results_due.size() != 0);
  endtask

  // Settings of the random phases: threshold and watched channel, then the
  // idling of sender and receiver. The last phase also holds the receiver off.
  int thr_plan[5] = '{2050, 1, 4095, 0, 1500};
  int chan_plan[5] = '{5, 0, 31, 17, 1};
  int send_plan[5] = '{0, 84, 0, 28, 0};
  int recv_plan[5] = '{0, 0, 84, 28, 0};

  initial begin
    int p;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the failsafe watching channel 3 at 950.
    write_reg(CFG_FS_THRESHOLD, 12'd950);
    write_reg(CFG_FS_CHANNEL, 12'd3);
    @(negedge clk_i);
    // All fields at zero, then all at their maximum.
    push_pulse(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    push_pulse(31, 4095, 4095, 4095, 4095, 4095, 1, 1, 1, 31, 1);
    // Full scale either way, the dead zone, reversal and both clamps.
    push_pulse(0, 2000, 1000, 2000, 1500, 0, 0, 0, 0, 8, 0);
    push_pulse(1, 1000, 1000, 2000, 1500, 0, 0, 0, 0, 8, 0);
    push_pulse(2, 1510, 1000, 2000, 1500, 20, 0, 0, 0, 8, 0);
    push_pulse(4, 1750, 1000, 2000, 1500, 0, 1, 0, 0, 8, 0);
    push_pulse(5, 500, 1000, 2000, 1500, 0, 0, 0, 0, 8, 0);
    push_pulse(6, 3000, 1000, 2000, 1500, 0, 0, 0, 0, 8, 0);
    // Inverted calibration: a negative divisor, then a saturating magnitude.
    push_pulse(7, 1000, 2000, 1000, 1500, 0, 0, 0, 0, 8, 0);
    push_pulse(9, 1700, 1200, 1000, 1500, 0, 0, 0, 0, 20, 0);
    // Channel limit set by the count and by the block's maximum.
    push_pulse(10, 1800, 1000, 2000, 1500, 0, 0, 0, 0, 8, 0);
    push_pulse(18, 1800, 1000, 2000, 1500, 0, 0, 0, 0, 20, 0);
    push_pulse(17, 1800, 1000, 2000, 1500, 0, 0, 0, 0, 31, 1);
    // Failsafe tripped low mid-frame and reported at the frame end.
    push_pulse(3, 900, 1000, 2000, 1500, 0, 0, 0, 0, 8, 0);
    push_pulse(4, 1500, 1000, 2000, 1500, 0, 0, 0, 0, 8, 1);
    // Tripped high on the closing item itself, then a clean frame.
    push_pulse(3, 1000, 500, 900, 700, 0, 0, 0, 0, 8, 1);
    push_pulse(0, 1500, 1000, 2000, 1500, 0, 0, 0, 0, 8, 1);
    // The failsafe still applies to a channel beyond the limit.
    push_pulse(3, 900, 1000, 2000, 1500, 0, 0, 0, 0, 2, 1);
    // Too few channels, just enough, and each receiver flag alone.
    push_pulse(0, 1500, 1000, 2000, 1500, 0, 0, 0, 0, 3, 1);
    push_pulse(0, 1500, 1000, 2000, 1500, 0, 0, 0, 0, 4, 1);
    push_pulse(1, 1500, 1000, 2000, 1500, 0, 0, 1, 0, 8, 1);
    push_pulse(2, 1500, 1000, 2000, 1500, 0, 0, 0, 1, 8, 1);
    // A raw value sitting exactly on the threshold does not trip.
    push_pulse(3, 950, 1000, 2000, 1500, 0, 0, 0, 0, 8, 1);
    wait_drained();

    for (p = 0; p < 5; p++) begin
      write_reg(CFG_FS_THRESHOLD, RAW_W'(thr_plan[p]));
      write_reg(CFG_FS_CHANNEL, RAW_W'(chan_plan[p]));
      @(negedge clk_i);
      send_idle_pct = send_plan[p];
      recv_stall_pct = recv_plan[p];
      // The last phase holds the receiver off while items keep coming.
      if (p == 4) hold_req = hold_req + 1;
      gen_frames(150);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_count == 0 && norm_results_due.size() == 0) begin
      $display("tb_rc_channel_normalizer passed");
    end else begin
      $display("tb_rc_channel_normalizer failed");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("tb_rc_channel_normalizer failed");
    $finish;
  end

endmodule

// File: files.f
sv/rcn_pkg.sv
sv/rcn_frame.sv
sv/rcn_div.sv
sv/rc_channel_normalizer.sv
sim/tb_rc_channel_normalizer.sv
